// ===== design/ppm_frame_decoder_defines.svh =====
// Assertion macros shared by the PPM frame decoder RTL.
// Depends on: nothing; users provide clk_i and rst_ni in scope.
`ifndef PPM_FRAME_DECODER_DEFINES_SVH
`define PPM_FRAME_DECODER_DEFINES_SVH

// Check a property on every clock edge outside reset
`define PFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger
`define PFD_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pfd_pkg.sv =====
// Shared types and constants for the PPM frame decoder.
// Depends on: nothing.
package pfd_pkg;

  // Channel table geometry
  localparam int MaxChannels = 16;
  localparam int SlotW       = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;
  localparam int NextW       = $clog2(MaxChannels + 1);
  localparam int CountW      = 5;
  localparam int CmpW        = 6;
  localparam int PulseW      = 16;
  localparam int TimeW       = 32;

  localparam logic [PulseW-1:0] SlotResetValue = 16'd1500;

  // Register reset values
  localparam logic [PulseW-1:0] SyncThrReset  = 16'd3000;
  localparam logic [PulseW-1:0] MinPulseReset = 16'd900;
  localparam logic [PulseW-1:0] MaxPulseReset = 16'd2100;
  localparam logic [CountW-1:0] ChanCntReset  = 5'd8;

  // Register map, index = byte address / 4
  typedef enum logic [1:0] {
    RegSyncThr   = 2'd0,
    RegMinPulse  = 2'd1,
    RegMaxPulse  = 2'd2,
    RegChanCount = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [PulseW-1:0] sync_thr;
    logic [PulseW-1:0] min_pulse;
    logic [PulseW-1:0] max_pulse;
    logic [CountW-1:0] chan_count;
  } cfg_t;

  // Channel table write port
  typedef struct packed {
    logic              en;
    logic [SlotW-1:0]  addr;
    logic [PulseW-1:0] data;
  } slot_wr_t;

endpackage

// ===== design/ppm_frame_decoder.sv =====
// PPM frame decoder: takes one rising-edge timestamp per item and returns
// one result per item. It accepts a new item every clock cycle while the
// output is not stalled; each item passes through the input register and
// then the result register, with the interval, window and channel table
// update done in the single logic stage between them. The
// input side stalls only while a finished result is held by a stalled
// output. Channel slots reset to 1500 us. Configure over APB only while idle.
// Depends on: pfd_pkg, pfd_cfg, pfd_slots, pfd_core.
module ppm_frame_decoder
  import pfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Edge items in
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] edge_time_us_i,
  input  logic [4:0]  query_channel_i,
  input  logic [15:0] default_value_i,
  // Result items out
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] interval_us_o,
  output logic        sync_seen_o,
  output logic        width_stored_o,
  output logic [3:0]  stored_index_o,
  output logic [15:0] query_result_o,
  output logic [31:0] frame_time_us_o,
  output logic [31:0] edge_total_o,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t              cfg;
  slot_wr_t          slot_wr;
  logic [SlotW-1:0]  slot_raddr;
  logic [PulseW-1:0] slot_rdata;

  pfd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pfd_slots u_slots (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (slot_wr),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  pfd_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .edge_time_us_i  (edge_time_us_i),
    .query_channel_i (query_channel_i),
    .default_value_i (default_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .interval_us_o   (interval_us_o),
    .sync_seen_o     (sync_seen_o),
    .width_stored_o  (width_stored_o),
    .stored_index_o  (stored_index_o),
    .query_result_o  (query_result_o),
    .frame_time_us_o (frame_time_us_o),
    .edge_total_o    (edge_total_o),
    .slot_wr_o       (slot_wr),
    .slot_raddr_o    (slot_raddr),
    .slot_rdata_i    (slot_rdata)
  );

endmodule

// ===== design/pfd_cfg.sv =====
// APB configuration registers of the PPM frame decoder.
// Depends on: pfd_pkg.
module pfd_cfg
  import pfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  // Write registers on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_thr   <= SyncThrReset;
      cfg_q.min_pulse  <= MinPulseReset;
      cfg_q.max_pulse  <= MaxPulseReset;
      cfg_q.chan_count <= ChanCntReset;
    end else if (wr_en) begin
      case (reg_idx)
        RegSyncThr:   cfg_q.sync_thr   <= pwdata[PulseW-1:0];
        RegMinPulse:  cfg_q.min_pulse  <= pwdata[PulseW-1:0];
        RegMaxPulse:  cfg_q.max_pulse  <= pwdata[PulseW-1:0];
        RegChanCount: cfg_q.chan_count <= pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Read back selected register
  always_comb begin
    case (reg_idx)
      RegSyncThr:   prdata = 32'(cfg_q.sync_thr);
      RegMinPulse:  prdata = 32'(cfg_q.min_pulse);
      RegMaxPulse:  prdata = 32'(cfg_q.max_pulse);
      RegChanCount: prdata = 32'(cfg_q.chan_count);
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/pfd_slots.sv =====
// Channel width table: one write port, one combinational read port.
// Depends on: pfd_pkg.
module pfd_slots
  import pfd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  slot_wr_t          wr_i,
  input  logic [SlotW-1:0]  raddr_i,
  output logic [PulseW-1:0] rdata_o
);

  logic [PulseW-1:0] slot_q [MaxChannels];

  // Store a channel width; reset fills every slot with the neutral pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxChannels; i++) begin
        slot_q[i] <= SlotResetValue;
      end
    end else if (wr_i.en) begin
      slot_q[wr_i.addr] <= wr_i.data;
    end
  end

  assign rdata_o = slot_q[raddr_i];

endmodule

// ===== design/pfd_core.sv =====
// Edge processing datapath: input register, interval and window logic,
// frame state and result register. Depends on: pfd_pkg, defines header.
`include "ppm_frame_decoder_defines.svh"

module pfd_core
  import pfd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [TimeW-1:0]  edge_time_us_i,
  input  logic [4:0]        query_channel_i,
  input  logic [PulseW-1:0] default_value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [TimeW-1:0]  interval_us_o,
  output logic              sync_seen_o,
  output logic              width_stored_o,
  output logic [3:0]        stored_index_o,
  output logic [PulseW-1:0] query_result_o,
  output logic [TimeW-1:0]  frame_time_us_o,
  output logic [TimeW-1:0]  edge_total_o,
  output slot_wr_t          slot_wr_o,
  output logic [SlotW-1:0]  slot_raddr_o,
  input  logic [PulseW-1:0] slot_rdata_i
);

  // Input register
  logic              in_valid_q;
  logic [TimeW-1:0]  in_time_q;
  logic [4:0]        in_query_q;
  logic [PulseW-1:0] in_dflt_q;

  // Frame state
  logic [TimeW-1:0]  prev_time_q;
  logic [TimeW-1:0]  sync_time_q;
  logic [NextW-1:0]  next_slot_q;
  logic [TimeW-1:0]  edge_cnt_q;

  // Result register
  logic              out_valid_q;
  logic [TimeW-1:0]  out_interval_q;
  logic              out_sync_q;
  logic              out_stored_q;
  logic [3:0]        out_index_q;
  logic [PulseW-1:0] out_query_q;
  logic [TimeW-1:0]  out_frame_q;
  logic [TimeW-1:0]  out_total_q;

  logic              advance;
  logic              accept;
  logic [TimeW-1:0]  interval;
  logic [CmpW-1:0]   eff_cnt;
  logic              is_sync;
  logic              in_window;
  logic              do_store;
  logic [SlotW-1:0]  slot_idx;
  logic              query_ok;
  logic [PulseW-1:0] query_val;
  logic              val_in_window;
  logic [PulseW-1:0] query_res;
  logic [TimeW-1:0]  frame_time;

  // Handshake: move an item on when the result register is empty or being taken
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  // Interval and classification
  assign interval  = in_time_q - prev_time_q;
  assign eff_cnt   = (CmpW'(cfg_i.chan_count) > CmpW'(MaxChannels)) ?
                     CmpW'(MaxChannels) : CmpW'(cfg_i.chan_count);
  assign is_sync   = interval > TimeW'(cfg_i.sync_thr);
  assign in_window = (interval >= TimeW'(cfg_i.min_pulse)) &&
                     (interval <= TimeW'(cfg_i.max_pulse));
  assign do_store  = !is_sync && in_window && (CmpW'(next_slot_q) < eff_cnt);
  assign slot_idx  = next_slot_q[SlotW-1:0];

  // Query after this edge's update: forward the width being written
  assign slot_raddr_o  = in_query_q[SlotW-1:0];
  assign query_ok      = CmpW'(in_query_q) < eff_cnt;
  assign query_val     = (do_store && (slot_idx == in_query_q[SlotW-1:0])) ?
                         interval[PulseW-1:0] : slot_rdata_i;
  assign val_in_window = (query_val >= cfg_i.min_pulse) &&
                         (query_val <= cfg_i.max_pulse);
  assign query_res     = (query_ok && val_in_window) ? query_val : in_dflt_q;
  assign frame_time    = is_sync ? in_time_q : sync_time_q;

  assign slot_wr_o.en   = advance && do_store;
  assign slot_wr_o.addr = slot_idx;
  assign slot_wr_o.data = interval[PulseW-1:0];

  // Hold the input item until it moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_time_q  <= edge_time_us_i;
      in_query_q <= query_channel_i;
      in_dflt_q  <= default_value_i;
    end
  end

  // Advance frame state per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_time_q <= '0;
      sync_time_q <= '0;
      next_slot_q <= '0;
      edge_cnt_q  <= '0;
    end else if (advance) begin
      prev_time_q <= in_time_q;
      sync_time_q <= frame_time;
      edge_cnt_q  <= edge_cnt_q + TimeW'(1);
      if (is_sync) begin
        next_slot_q <= '0;
      end else if (do_store) begin
        next_slot_q <= next_slot_q + NextW'(1);
      end
    end
  end

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_interval_q <= interval;
      out_sync_q     <= is_sync;
      out_stored_q   <= do_store;
      out_index_q    <= do_store ? 4'(slot_idx) : 4'd0;
      out_query_q    <= query_res;
      out_frame_q    <= frame_time;
      out_total_q    <= edge_cnt_q + TimeW'(1);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign interval_us_o   = out_interval_q;
  assign sync_seen_o     = out_sync_q;
  assign width_stored_o  = out_stored_q;
  assign stored_index_o  = out_index_q;
  assign query_result_o  = out_query_q;
  assign frame_time_us_o = out_frame_q;
  assign edge_total_o    = out_total_q;

  // A sync edge never stores a width
  `PFD_ASSERT(a_sync_no_store, !(out_valid_q && out_sync_q && out_stored_q),
              "sync edge stored a channel width")
  // The slot pointer never passes the table size
  `PFD_ASSERT(a_slot_bound, next_slot_q <= NextW'(MaxChannels),
              "next slot beyond channel table")
  // A sync edge restarts the frame
  `PFD_ASSERT_NEXT(a_sync_restart, advance && is_sync, next_slot_q == '0,
                   "slot pointer not cleared after sync")
  // Each processed item bumps the edge total by one
  `PFD_ASSERT_NEXT(a_edge_count, advance,
                   edge_total_o == $past(edge_cnt_q) + TimeW'(1),
                   "edge total out of step")

endmodule

// ===== test/ppm_decode_check_pkg.sv =====
// Scoreboard for the PPM frame decoder test: mirrors the registers and channel table,
// predicts one result per accepted edge item and compares results field by field.
// Depends on: pfd_pkg (register indexes, table size, reset values).
package ppm_decode_check_pkg;
  import pfd_pkg::*;

  typedef struct packed {
    logic [31:0] interval_us;
    logic        sync_seen;
    logic        width_stored;
    logic [3:0]  stored_index;
    logic [15:0] query_result;
    logic [31:0] frame_time_us;
    logic [31:0] edge_total;
  } edge_result_t;

  class ppm_channel_scoreboard;
    // Register mirror
    logic [15:0]  sync_thr;
    logic [15:0]  min_pulse;
    logic [15:0]  max_pulse;
    logic [4:0]   chan_count;
    // Decoder state mirror
    logic [31:0]  last_edge_time;
    logic [31:0]  frame_start;
    logic [31:0]  edges_seen;
    logic [4:0]   slot_ptr;
    logic [15:0]  slot_width [MaxChannels];
    // Results still owed by the block, oldest first
    edge_result_t pending_decodes [$];
    int           errors;
    int           syncs;
    int           stores;
    int           answered;

    function new();
      sync_thr       = SyncThrReset;
      min_pulse      = MinPulseReset;
      max_pulse      = MaxPulseReset;
      chan_count     = ChanCntReset;
      last_edge_time = '0;
      frame_start    = '0;
      edges_seen     = '0;
      slot_ptr       = '0;
      foreach (slot_width[i]) slot_width[i] = SlotResetValue;
      errors   = 0;
      syncs    = 0;
      stores   = 0;
      answered = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [31:0] value);
      case (idx)
        RegSyncThr:   sync_thr   = value[15:0];
        RegMinPulse:  min_pulse  = value[15:0];
        RegMaxPulse:  max_pulse  = value[15:0];
        RegChanCount: chan_count = value[4:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(reg_idx_e idx);
      case (idx)
        RegSyncThr:   return {16'd0, sync_thr};
        RegMinPulse:  return {16'd0, min_pulse};
        RegMaxPulse:  return {16'd0, max_pulse};
        default:      return {27'd0, chan_count};
      endcase
    endfunction

    // Saturate the programmed count at the table size
    function int unsigned live_channels();
      return (32'(chan_count) > MaxChannels) ? MaxChannels : 32'(chan_count);
    endfunction

    // Advance the decoder by one accepted edge item and queue its result
    function void note_edge(logic [31:0] stamp, logic [4:0] chan, logic [15:0] dflt);
      edge_result_t r;
      int unsigned  lim;
      logic [15:0]  w;
      lim            = live_channels();
      r              = '0;
      r.interval_us  = stamp - last_edge_time;
      last_edge_time = stamp;
      edges_seen     = edges_seen + 32'd1;

      // Sync test wins over the pulse window
      if (r.interval_us > {16'd0, sync_thr}) begin
        r.sync_seen = 1'b1;
        slot_ptr    = '0;
        frame_start = stamp;
        syncs++;
      end else if (r.interval_us >= {16'd0, min_pulse} && r.interval_us <= {16'd0, max_pulse}
                   && 32'(slot_ptr) < lim) begin
        r.width_stored             = 1'b1;
        r.stored_index             = slot_ptr[3:0];
        slot_width[slot_ptr[3:0]]  = r.interval_us[15:0];
        slot_ptr                   = slot_ptr + 5'd1;
        stores++;
      end

      // Query after the update, checked against the current window
      r.query_result = dflt;
      if (32'(chan) < lim) begin
        w = slot_width[chan[3:0]];
        if (w >= min_pulse && w <= max_pulse) begin
          r.query_result = w;
          answered++;
        end
      end

      r.frame_time_us = frame_start;
      r.edge_total    = edges_seen;
      pending_decodes.push_back(r);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("MISMATCH: %s", what);
      else if (errors == 41) $display("MISMATCH: further mismatches counted but not shown");
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want, logic [31:0] idx);
      if (got !== want)
        report($sformatf("edge %0d %s got 0x%0h expected 0x%0h", idx, name, got, want));
    endtask

    // Match one result item against the oldest prediction
    task check_result(edge_result_t got);
      edge_result_t want;
      if (pending_decodes.size() == 0) begin
        report($sformatf("result with no edge pending, interval_us 0x%0h", got.interval_us));
        return;
      end
      want = pending_decodes.pop_front();
      compare_field("interval_us", got.interval_us, want.interval_us, want.edge_total);
      compare_field("sync_seen", 32'(got.sync_seen), 32'(want.sync_seen), want.edge_total);
      compare_field("width_stored", 32'(got.width_stored), 32'(want.width_stored),
                    want.edge_total);
      compare_field("stored_index", 32'(got.stored_index), 32'(want.stored_index),
                    want.edge_total);
      compare_field("query_result", 32'(got.query_result), 32'(want.query_result),
                    want.edge_total);
      compare_field("frame_time_us", got.frame_time_us, want.frame_time_us, want.edge_total);
      compare_field("edge_total", got.edge_total, want.edge_total, want.edge_total);
    endtask
  endclass

endpackage

// ===== test/ppm_frame_decoder_test.sv =====
// Self-checking test of ppm_frame_decoder: directed edges, then random PPM frames
// and noise under several register settings with random input gaps and output stalls.
// Depends on: pfd_pkg, ppm_decode_check_pkg and the decoder RTL.
module ppm_frame_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pfd_pkg::*;
  import ppm_decode_check_pkg::*;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int QUIET_LIMIT     = 3000;
  localparam int SETTINGS_N      = 9;

  // Register settings per random phase
  int unsigned set_thr   [SETTINGS_N] = '{3000, 65535, 2500, 0, 3000, 3000, 400, 3000, 3000};
  int unsigned set_min   [SETTINGS_N] = '{900, 0, 1000, 0, 2000, 900, 900, 800, 900};
  int unsigned set_max   [SETTINGS_N] = '{2100, 65535, 2000, 0, 1000, 2100, 2100, 2200, 2100};
  int unsigned set_cnt   [SETTINGS_N] = '{8, 16, 31, 4, 8, 0, 12, 17, 8};
  int          set_items [SETTINGS_N] = '{250, 300, 250, 150, 150, 150, 150, 300, 250};
  bit          set_idle  [SETTINGS_N] = '{1, 1, 0, 1, 1, 1, 1, 0, 1};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] edge_time_us_i = '0;
  logic [4:0]  query_channel_i = '0;
  logic [15:0] default_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] interval_us_o;
  logic        sync_seen_o;
  logic        width_stored_o;
  logic [3:0]  stored_index_o;
  logic [15:0] query_result_o;
  logic [31:0] frame_time_us_o;
  logic [31:0] edge_total_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ppm_channel_scoreboard sb;
  logic [31:0] edge_clock = '0;
  bit          idle_on = 1'b1;
  bit          hold_off_req = 1'b0;
  int          quiet_cycles = 0;

  ppm_frame_decoder uut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .edge_time_us_i, .query_channel_i, .default_value_i,
    .out_valid_o, .out_stall_i, .interval_us_o, .sync_seen_o, .width_stored_o,
    .stored_index_o, .query_result_o, .frame_time_us_o, .edge_total_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [4:0] pick_query();
    if ($urandom_range(0, 99) < 60) return 5'($urandom_range(0, 16));
    return 5'($urandom_range(0, 31));
  endfunction

  // Gap long enough to mark frame sync under the current threshold
  function automatic logic [31:0] pick_sync_gap();
    if ($urandom_range(0, 9) == 0) return $urandom() | 32'h0002_0000;
    return sb.sync_thr + 1 + $urandom_range(0, 6000);
  endfunction

  // Channel pulse, mostly inside the window, sometimes just outside it or random
  function automatic logic [31:0] pick_pulse();
    if (sb.min_pulse <= sb.max_pulse && $urandom_range(0, 99) < 85)
      return sb.min_pulse + $urandom_range(0, sb.max_pulse - sb.min_pulse);
    case ($urandom_range(0, 2))
      0:       return sb.min_pulse - 1;
      1:       return sb.max_pulse + 1;
      default: return $urandom_range(0, 4000);
    endcase
  endfunction

  // Offer one edge item and hold it until accepted
  task automatic send_edge(logic [31:0] stamp, logic [4:0] chan, logic [15:0] dflt);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    edge_time_us_i  = stamp;
    query_channel_i = chan;
    default_value_i = dflt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_edge(stamp, chan, dflt);
    edge_clock = stamp;
  endtask

  task automatic send_after(logic [31:0] gap_us, logic [4:0] chan, logic [15:0] dflt);
    send_edge(edge_clock + gap_us, chan, dflt);
  endtask

  task automatic stop_edges();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic drain();
    while (sb.pending_decodes.size() != 0) @(posedge clk_i);
  endtask

  // Write one register, then read it back
  task automatic write_and_verify(reg_idx_e idx, logic [31:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_reg(idx, value);
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== sb.reg_value(idx))
      sb.report($sformatf("register %s read 0x%0h expected 0x%0h", idx.name(), prdata,
                          sb.reg_value(idx)));
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Random frames: sync gap then a run of pulses, with some noise mixed in
  task automatic run_frames(int n);
    int sent;
    int pulses;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 99) < 12) begin
        if ($urandom_range(0, 2) == 0) send_edge($urandom(), pick_query(), 16'($urandom()));
        else send_after($urandom_range(0, 70000), pick_query(), 16'($urandom()));
        sent++;
      end else begin
        send_after(pick_sync_gap(), pick_query(), 16'($urandom()));
        sent++;
        pulses = $urandom_range(0, sb.live_channels() + 2);
        for (int i = 0; i < pulses && sent < n; i++) begin
          send_after(pick_pulse(), pick_query(), 16'($urandom()));
          sent++;
        end
      end
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin : result_receiver
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_stall_i = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
        out_stall_i  = 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < 25) begin
        n = pick_gap() + 1;
        out_stall_i = 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  // Check every accepted result item
  always @(posedge clk_i) begin : result_monitor
    edge_result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.interval_us   = interval_us_o;
      got.sync_seen     = sync_seen_o;
      got.width_stored  = width_stored_o;
      got.stored_index  = stored_index_o;
      got.query_result  = query_result_o;
      got.frame_time_us = frame_time_us_o;
      got.edge_total    = edge_total_o;
      sb.check_result(got);
    end
  end

  // End the run when neither channel moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    sb = new();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed edges under reset settings: first edge from time zero, window
    // limits, full table, threshold boundary, timestamp wrap and zero interval
    send_edge(32'd1000, 5'd0, 16'h0000);
    send_after(32'd5000, 5'd0, 16'hFFFF);
    send_after(32'd900, 5'd31, 16'hFFFF);
    send_after(32'd2100, 5'd1, 16'h0000);
    send_after(32'd899, 5'd2, 16'h1234);
    send_after(32'd2101, 5'd1, 16'h0000);
    for (int i = 0; i < 6; i++) send_after(32'd1000 + 100 * i, 5'(i + 2), 16'hA5A5);
    send_after(32'd1200, 5'd8, 16'h5A5A);
    send_after(32'd3000, 5'd7, 16'h0000);
    send_after(32'd3001, 5'd16, 16'h0000);
    send_edge(32'hFFFF_FF00, 5'd15, 16'hFFFF);
    send_after(32'd1024, 5'd0, 16'h0000);
    send_after(32'd0, 5'd0, 16'hFFFF);
    send_edge(32'hFFFF_FFFF, 5'd3, 16'h8001);
    send_after(32'd1, 5'd0, 16'h7FFE);
    send_after(32'd1500, 5'd0, 16'h0000);
    stop_edges();
    drain();

    // Random frames under each register setting
    for (int p = 0; p < SETTINGS_N; p++) begin
      write_and_verify(RegSyncThr, set_thr[p]);
      write_and_verify(RegMinPulse, set_min[p]);
      write_and_verify(RegMaxPulse, set_max[p]);
      write_and_verify(RegChanCount, set_cnt[p]);
      idle_on = set_idle[p];
      if (p == 1) hold_off_req = 1'b1;
      run_frames(set_items[p]);
      stop_edges();
      drain();
    end

    repeat (4) @(posedge clk_i);
    if (sb.pending_decodes.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_decodes.size()));
    $display("Decoded %0d edges over %0d register settings: %0d frame syncs, %0d widths stored",
             sb.edges_seen, SETTINGS_N + 1, sb.syncs, sb.stores);
    $display("%0d queries answered from the channel table, %0d mismatches",
             sb.answered, sb.errors);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== ppm_frame_decoder.f =====
+incdir+design
design/pfd_pkg.sv
design/pfd_cfg.sv
design/pfd_slots.sv
design/pfd_core.sv
design/ppm_frame_decoder.sv
test/ppm_decode_check_pkg.sv
test/ppm_frame_decoder_test.sv
